FILE: hdl/vpa_pkg.sv
// ----------------------------------------------------------------------------
// Variable partition allocator package
// Shared types, constants and codes for the partition allocator.
// ----------------------------------------------------------------------------
`default_nettype none
package vpa_pkg;

  localparam int MAX_PARTITIONS = 32;
  localparam int SIZE_BITS      = 16;
  localparam int IDX_BITS       = $clog2(MAX_PARTITIONS);
  localparam int CNT_BITS       = $clog2(MAX_PARTITIONS + 1);
  localparam int OWNER_BITS     = 8;

  localparam logic [SIZE_BITS-1:0] TOTAL_SIZE_RESET = SIZE_BITS'(1024);

  localparam logic       OP_ALLOC = 1'b0;
  localparam logic       OP_FREE  = 1'b1;

  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;
  localparam logic [1:0] FIT_NONE  = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_SPACE  = 2'd1;
  localparam logic [1:0] ST_NO_OWNER  = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic                   opcode;
    logic [1:0]             fit_policy;
    logic [15:0]            request_size;
    logic [7:0]             owner_id;
  } in_req_t;

  typedef struct packed {
    logic [1:0]             status;
    logic [15:0]            start_address;
    logic [15:0]            block_size;
    logic [4:0]             partition_index;
  } out_rsp_t;

  typedef struct packed {
    logic [SIZE_BITS-1:0]  start;
    logic [SIZE_BITS-1:0]  size;
    logic [OWNER_BITS-1:0] owner;
    logic                  used;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_WAIT,
    S_DECIDE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_SPLIT,
    S_FREE_RD,
    S_FREE_MERGE,
    S_REMOVE_RD,
    S_REMOVE_WR,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

FILE: hdl/vpa_table_ram.sv
// ----------------------------------------------------------------------------
// Partition table memory
// One-write, one-read synchronous memory holding the partition entries.
// ----------------------------------------------------------------------------
`default_nettype none
module vpa_table_ram (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic [vpa_pkg::IDX_BITS-1:0] waddr,
  input  wire vpa_pkg::entry_t              wdata,
  input  wire logic [vpa_pkg::IDX_BITS-1:0] raddr,
  output vpa_pkg::entry_t                   rdata
);

  vpa_pkg::entry_t mem [vpa_pkg::MAX_PARTITIONS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: hdl/vpa_ctrl.sv
// ----------------------------------------------------------------------------
// Partition allocator sequencer
// Scans the table, shifts entries for splits and merges, forms results.
// ----------------------------------------------------------------------------
`default_nettype none
module vpa_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire vpa_pkg::in_req_t             req,
  input  wire logic                         cfg_we,
  input  wire logic [15:0]                  cfg_total,
  output logic                              busy,
  output logic                              rsp_valid,
  output vpa_pkg::out_rsp_t                 rsp,
  output logic                              ram_we,
  output logic [vpa_pkg::IDX_BITS-1:0]      ram_waddr,
  output vpa_pkg::entry_t                   ram_wdata,
  output logic [vpa_pkg::IDX_BITS-1:0]      ram_raddr,
  input  wire vpa_pkg::entry_t              ram_rdata
);

  localparam int IB = vpa_pkg::IDX_BITS;
  localparam int CB = vpa_pkg::CNT_BITS;
  localparam int SB = vpa_pkg::SIZE_BITS;

  vpa_pkg::state_t state_r, state_nxt;
  vpa_pkg::in_req_t req_r, req_nxt;
  logic [CB-1:0] cnt_r, cnt_nxt;
  logic [CB-1:0] i_r, i_nxt;
  logic [IB-1:0] pick_r, pick_nxt;
  logic [SB-1:0] left_r, left_nxt;
  logic          found_r, found_nxt;
  logic [SB-1:0] total_r, total_nxt;
  vpa_pkg::entry_t cur_r, cur_nxt;
  vpa_pkg::entry_t prv_r, prv_nxt;
  logic          prvok_r, prvok_nxt;
  logic          clr_r, clr_nxt;
  logic          mprev_r, mprev_nxt;
  vpa_pkg::out_rsp_t rsp_r, rsp_nxt;
  logic          rv_r, rv_nxt;

  vpa_pkg::entry_t zero_e;
  logic [SB-1:0]   lft;
  logic            fits;

  assign zero_e = '0;
  assign busy = (state_r != vpa_pkg::S_IDLE) || clr_r;
  assign rsp_valid = rv_r;
  assign rsp = rsp_r;
  assign fits = !ram_rdata.used && (ram_rdata.size >= req_r.request_size);
  assign lft = ram_rdata.size - req_r.request_size;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vpa_pkg::S_IDLE;
      cnt_r   <= CB'(1);
      total_r <= vpa_pkg::TOTAL_SIZE_RESET;
      clr_r   <= 1'b1;
      rv_r    <= 1'b0;
      i_r     <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      total_r <= total_nxt;
      clr_r   <= clr_nxt;
      rv_r    <= rv_nxt;
      i_r     <= i_nxt;
    end
    req_r <= req_nxt; pick_r <= pick_nxt; left_r <= left_nxt; found_r <= found_nxt;
    cur_r <= cur_nxt; prv_r <= prv_nxt; prvok_r <= prvok_nxt;
    mprev_r <= mprev_nxt; rsp_r <= rsp_nxt;
  end

  always_comb begin
    state_nxt = state_r; req_nxt = req_r; cnt_nxt = cnt_r; i_nxt = i_r;
    pick_nxt = pick_r; left_nxt = left_r; found_nxt = found_r; total_nxt = total_r;
    cur_nxt = cur_r; prv_nxt = prv_r; prvok_nxt = prvok_r; clr_nxt = clr_r;
    mprev_nxt = mprev_r; rsp_nxt = rsp_r; rv_nxt = 1'b0;
    ram_we = 1'b0; ram_waddr = '0; ram_wdata = zero_e; ram_raddr = i_r[IB-1:0];

    if (cfg_we) begin
      total_nxt = cfg_total;
      clr_nxt = 1'b1;
      i_nxt = '0;
    end else if (clr_r) begin
      ram_we = 1'b1;
      ram_waddr = i_r[IB-1:0];
      ram_wdata = zero_e;
      if (i_r == '0) ram_wdata.size = total_r;
      if (i_r == CB'(vpa_pkg::MAX_PARTITIONS - 1)) begin
        clr_nxt = 1'b0;
        cnt_nxt = CB'(1);
        i_nxt = '0;
      end else begin
        i_nxt = i_r + CB'(1);
      end
    end else begin
      unique case (state_r)
        vpa_pkg::S_IDLE: begin
          if (start) begin
            req_nxt = req;
            i_nxt = '0;
            found_nxt = 1'b0;
            prvok_nxt = 1'b0;
            ram_raddr = '0;
            if (req.opcode == vpa_pkg::OP_ALLOC &&
                (req.fit_policy == vpa_pkg::FIT_NONE || req.request_size == '0)) begin
              rsp_nxt = '0; rsp_nxt.status = vpa_pkg::ST_NO_SPACE;
              state_nxt = vpa_pkg::S_DONE;
            end else begin
              state_nxt = vpa_pkg::S_SCAN;
            end
          end
        end
        vpa_pkg::S_SCAN: begin
          // Data for entry i_r is on ram_rdata.
          if (req_r.opcode == vpa_pkg::OP_FREE) begin
            if (ram_rdata.used && ram_rdata.owner == req_r.owner_id) begin
              cur_nxt = ram_rdata;
              pick_nxt = i_r[IB-1:0];
              ram_raddr = IB'(i_r + CB'(1));
              state_nxt = vpa_pkg::S_FREE_RD;
            end else if (i_r + CB'(1) >= cnt_r) begin
              rsp_nxt = '0; rsp_nxt.status = vpa_pkg::ST_NO_OWNER;
              state_nxt = vpa_pkg::S_DONE;
            end else begin
              prv_nxt = ram_rdata; prvok_nxt = 1'b1;
              i_nxt = i_r + CB'(1);
              ram_raddr = IB'(i_r + CB'(1));
            end
          end else begin
            if (fits && (!found_r ||
                (req_r.fit_policy == vpa_pkg::FIT_BEST && lft < left_r) ||
                (req_r.fit_policy == vpa_pkg::FIT_WORST && lft > left_r))) begin
              found_nxt = 1'b1; pick_nxt = i_r[IB-1:0]; left_nxt = lft;
              cur_nxt = ram_rdata;
            end
            if ((fits && !found_r && req_r.fit_policy == vpa_pkg::FIT_FIRST) ||
                i_r + CB'(1) >= cnt_r) begin
              state_nxt = vpa_pkg::S_DECIDE;
            end else begin
              i_nxt = i_r + CB'(1);
              ram_raddr = IB'(i_r + CB'(1));
            end
          end
        end
        vpa_pkg::S_DECIDE: begin
          if (!found_r) begin
            rsp_nxt = '0; rsp_nxt.status = vpa_pkg::ST_NO_SPACE;
            state_nxt = vpa_pkg::S_DONE;
          end else if (left_r == '0) begin
            ram_we = 1'b1; ram_waddr = pick_r;
            ram_wdata = cur_r; ram_wdata.used = 1'b1; ram_wdata.owner = req_r.owner_id;
            rsp_nxt.status = vpa_pkg::ST_OK;
            rsp_nxt.start_address = cur_r.start;
            rsp_nxt.block_size = cur_r.size;
            rsp_nxt.partition_index = 5'(pick_r);
            state_nxt = vpa_pkg::S_DONE;
          end else if (cnt_r >= CB'(vpa_pkg::MAX_PARTITIONS)) begin
            rsp_nxt = '0; rsp_nxt.status = vpa_pkg::ST_FULL;
            state_nxt = vpa_pkg::S_DONE;
          end else begin
            i_nxt = cnt_r;
            state_nxt = vpa_pkg::S_SHIFT_RD;
          end
        end
        vpa_pkg::S_SHIFT_RD: begin
          // Move entries up: entry i_r gets entry i_r-1, down to pick+2.
          if (i_r <= CB'(pick_r) + CB'(1)) begin
            state_nxt = vpa_pkg::S_SPLIT;
          end else begin
            ram_raddr = IB'(i_r - CB'(1));
            state_nxt = vpa_pkg::S_SHIFT_WR;
          end
        end
        vpa_pkg::S_SHIFT_WR: begin
          ram_we = 1'b1; ram_waddr = i_r[IB-1:0]; ram_wdata = ram_rdata;
          i_nxt = i_r - CB'(1);
          state_nxt = vpa_pkg::S_SHIFT_RD;
        end
        vpa_pkg::S_SPLIT: begin
          // Two writes: remainder first, then the used part.
          if (!found_r) begin
            ram_we = 1'b1; ram_waddr = pick_r;
            ram_wdata.start = cur_r.start; ram_wdata.size = req_r.request_size;
            ram_wdata.owner = req_r.owner_id; ram_wdata.used = 1'b1;
            cnt_nxt = cnt_r + CB'(1);
            rsp_nxt.status = vpa_pkg::ST_OK;
            rsp_nxt.start_address = cur_r.start;
            rsp_nxt.block_size = req_r.request_size;
            rsp_nxt.partition_index = 5'(pick_r);
            state_nxt = vpa_pkg::S_DONE;
          end else begin
            ram_we = 1'b1; ram_waddr = pick_r + IB'(1);
            ram_wdata.start = cur_r.start + req_r.request_size;
            ram_wdata.size = left_r;
            found_nxt = 1'b0;
          end
        end
        vpa_pkg::S_FREE_RD: begin
          // ram_rdata holds entry pick+1.
          cur_nxt.used = 1'b0; cur_nxt.owner = '0;
          mprev_nxt = prvok_r && !prv_r.used;
          if (i_r + CB'(1) < cnt_r && !ram_rdata.used) begin
            cur_nxt.size = cur_r.size + ram_rdata.size;
            state_nxt = vpa_pkg::S_REMOVE_RD;
            i_nxt = i_r + CB'(1);
          end else begin
            state_nxt = vpa_pkg::S_FREE_MERGE;
          end
        end
        vpa_pkg::S_REMOVE_RD: begin
          // Move entry i_r+1 to i_r until the end, then clear the last.
          if (i_r + CB'(1) >= cnt_r) begin
            ram_we = 1'b1; ram_waddr = i_r[IB-1:0]; ram_wdata = zero_e;
            cnt_nxt = cnt_r - CB'(1);
            state_nxt = vpa_pkg::S_FREE_MERGE;
          end else begin
            ram_raddr = IB'(i_r + CB'(1));
            state_nxt = vpa_pkg::S_REMOVE_WR;
          end
        end
        vpa_pkg::S_REMOVE_WR: begin
          ram_we = 1'b1; ram_waddr = i_r[IB-1:0]; ram_wdata = ram_rdata;
          i_nxt = i_r + CB'(1);
          state_nxt = vpa_pkg::S_REMOVE_RD;
        end
        vpa_pkg::S_FREE_MERGE: begin
          if (mprev_r) begin
            mprev_nxt = 1'b0;
            cur_nxt.start = prv_r.start;
            cur_nxt.size = prv_r.size + cur_r.size;
            pick_nxt = pick_r - IB'(1);
            i_nxt = CB'(pick_r);
            state_nxt = vpa_pkg::S_REMOVE_RD;
          end else begin
            ram_we = 1'b1; ram_waddr = pick_r; ram_wdata = cur_r;
            rsp_nxt.status = vpa_pkg::ST_OK;
            rsp_nxt.start_address = cur_r.start;
            rsp_nxt.block_size = cur_r.size;
            rsp_nxt.partition_index = 5'(pick_r);
            state_nxt = vpa_pkg::S_DONE;
          end
        end
        vpa_pkg::S_DONE: begin
          rv_nxt = 1'b1;
          state_nxt = vpa_pkg::S_IDLE;
        end
        default: state_nxt = vpa_pkg::S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: hdl/variable_partition_allocator_top.sv
// ----------------------------------------------------------------------------
// Variable partition allocator
// Allocates and frees contiguous partitions by first, best or worst fit.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. It carries an
// opcode, a fit policy, a size and an owner. Exactly one result follows,
// shown for one cycle with out_valid high; the receiver cannot stall it.
// The partition table lives in one synchronous memory, and the sequencer
// reads one entry per cycle while it scans. An allocate scans the entries,
// and on a split shifts the entries above the pick up by one; a free scans
// for the owner and, to merge with the next or the previous entry, moves
// the entries above down by one. A rejected policy or size skips the scan.
// The result shows in the first cycle with busy low, and the next request
// can be taken in that same cycle. Reset and every write of cfg_total_size
// start a clearing pass over every entry of the memory, during which busy
// is high and the table becomes one free partition of the configured size
// (1024 at reset). The user must make configuration writes only while the
// block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none
module variable_partition_allocator_top (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire vpa_pkg::in_req_t  in_req,
  output logic                   out_valid,
  output vpa_pkg::out_rsp_t      out_rsp,
  input  wire logic              cfg_we,
  input  wire logic [15:0]       cfg_total_size
);

  logic                         ram_we;
  logic [vpa_pkg::IDX_BITS-1:0] ram_waddr, ram_raddr;
  vpa_pkg::entry_t              ram_wdata, ram_rdata;

  vpa_ctrl u_ctrl (
    .clk, .rst_n, .start, .req(in_req), .cfg_we, .cfg_total(cfg_total_size),
    .busy, .rsp_valid(out_valid), .rsp(out_rsp),
    .ram_we, .ram_waddr, .ram_wdata, .ram_raddr, .ram_rdata
  );

  vpa_table_ram u_ram (
    .clk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  a_valid_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("busy did not rise after a request");
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rsp.status != vpa_pkg::ST_OK) |-> (out_rsp.block_size == '0))
    else $error("failed result carries a size");

endmodule
`default_nettype wire

FILE: test/variable_partition_allocator_top_test.sv
// ----------------------------------------------------------------------------
// Variable partition allocator testbench
// Drives allocate and free requests under several memory sizes, predicts each
// result from a table model of the partitions and checks every result field.
// ----------------------------------------------------------------------------
`default_nettype none

class vpa_scoreboard;
  localparam int NPART = vpa_pkg::MAX_PARTITIONS;
  bit [15:0] tbl_start [NPART];
  bit [15:0] tbl_size [NPART];
  bit [7:0] tbl_owner [NPART];
  bit tbl_used [NPART];
  int tbl_count;
  vpa_pkg::out_rsp_t pending_rsp[$];
  int mismatches;

  function void clear_table(bit [15:0] total);
    for (int i = 0; i < NPART; i++) begin
      tbl_start[i] = 0;
      tbl_size[i] = 0;
      tbl_owner[i] = 0;
      tbl_used[i] = 0;
    end
    tbl_size[0] = total;
    tbl_count = 1;
  endfunction

  function void drop_entry(int idx);
    for (int i = idx; i + 1 < tbl_count; i++) begin
      tbl_start[i] = tbl_start[i+1];
      tbl_size[i] = tbl_size[i+1];
      tbl_owner[i] = tbl_owner[i+1];
      tbl_used[i] = tbl_used[i+1];
    end
    tbl_count--;
    tbl_start[tbl_count] = 0;
    tbl_size[tbl_count] = 0;
    tbl_owner[tbl_count] = 0;
    tbl_used[tbl_count] = 0;
  endfunction

  function vpa_pkg::out_rsp_t allocate(vpa_pkg::in_req_t r);
    vpa_pkg::out_rsp_t o;
    int pick;
    bit found;
    bit [15:0] best_left;
    bit [15:0] left;
    o = '0;
    pick = 0;
    found = 0;
    best_left = 0;
    o.status = vpa_pkg::ST_NO_SPACE;
    if (r.fit_policy > vpa_pkg::FIT_WORST || r.request_size == 0) return o;
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_used[i] || tbl_size[i] < r.request_size) continue;
      left = tbl_size[i] - r.request_size;
      if (!found) begin
        found = 1;
        pick = i;
        best_left = left;
        if (r.fit_policy == vpa_pkg::FIT_FIRST) break;
      end else if ((r.fit_policy == vpa_pkg::FIT_BEST && left < best_left) ||
                   (r.fit_policy == vpa_pkg::FIT_WORST && left > best_left)) begin
        pick = i;
        best_left = left;
      end
    end
    if (!found) return o;
    if (best_left != 0) begin
      if (tbl_count >= NPART) begin
        o.status = vpa_pkg::ST_FULL;
        return o;
      end
      for (int i = tbl_count; i > pick + 1; i--) begin
        tbl_start[i] = tbl_start[i-1];
        tbl_size[i] = tbl_size[i-1];
        tbl_owner[i] = tbl_owner[i-1];
        tbl_used[i] = tbl_used[i-1];
      end
      tbl_start[pick+1] = tbl_start[pick] + r.request_size;
      tbl_size[pick+1] = best_left;
      tbl_owner[pick+1] = 0;
      tbl_used[pick+1] = 0;
      tbl_count++;
      tbl_size[pick] = r.request_size;
    end
    tbl_used[pick] = 1;
    tbl_owner[pick] = r.owner_id;
    o.status = vpa_pkg::ST_OK;
    o.start_address = tbl_start[pick];
    o.block_size = tbl_size[pick];
    o.partition_index = pick[4:0];
    return o;
  endfunction

  function vpa_pkg::out_rsp_t release_owner(bit [7:0] owner);
    vpa_pkg::out_rsp_t o;
    int idx;
    o = '0;
    idx = -1;
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_used[i] && tbl_owner[i] == owner) begin
        idx = i;
        break;
      end
    end
    if (idx < 0) begin
      o.status = vpa_pkg::ST_NO_OWNER;
      return o;
    end
    tbl_used[idx] = 0;
    tbl_owner[idx] = 0;
    if (idx + 1 < tbl_count && !tbl_used[idx+1]) begin
      tbl_size[idx] = tbl_size[idx] + tbl_size[idx+1];
      drop_entry(idx + 1);
    end
    if (idx > 0 && !tbl_used[idx-1]) begin
      tbl_size[idx-1] = tbl_size[idx-1] + tbl_size[idx];
      drop_entry(idx);
      idx--;
    end
    o.status = vpa_pkg::ST_OK;
    o.start_address = tbl_start[idx];
    o.block_size = tbl_size[idx];
    o.partition_index = idx[4:0];
    return o;
  endfunction

  function void note_request(vpa_pkg::in_req_t r);
    if (r.opcode == vpa_pkg::OP_ALLOC) pending_rsp.push_back(allocate(r));
    else pending_rsp.push_back(release_owner(r.owner_id));
  endfunction

  function void check_result(vpa_pkg::out_rsp_t got);
    vpa_pkg::out_rsp_t want;
    if (pending_rsp.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %p", got);
      return;
    end
    want = pending_rsp[0];
    pending_rsp.delete(0);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
    end
  endfunction
endclass

module variable_partition_allocator_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  vpa_pkg::in_req_t in_req;
  logic out_valid;
  vpa_pkg::out_rsp_t out_rsp;
  logic cfg_we;
  logic [15:0] cfg_total_size;

  vpa_scoreboard alloc_board;
  int cycle_count;
  bit [15:0] mem_size;
  int burst_left;

  variable_partition_allocator_top u_top (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_req(in_req),
    .out_valid(out_valid),
    .out_rsp(out_rsp),
    .cfg_we(cfg_we),
    .cfg_total_size(cfg_total_size)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid) alloc_board.check_result(out_rsp);
    if (cycle_count > 2000000) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_request(vpa_pkg::in_req_t r);
    if (burst_left == 0) begin
      repeat ($urandom_range(0, 1) ? $urandom_range(1, 60) : 0) @(negedge clk);
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    @(negedge clk);
    start <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (busy);
    alloc_board.note_request(r);
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic wait_drained();
    while (alloc_board.pending_rsp.size() != 0) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  task automatic write_size(bit [15:0] total);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_total_size <= total;
    @(negedge clk);
    cfg_we <= 1'b0;
    mem_size = total;
    alloc_board.clear_table(total);
    repeat (2) @(negedge clk);
  endtask

  function automatic vpa_pkg::in_req_t make_req(bit op, bit [1:0] fit, bit [15:0] sz,
                                                bit [7:0] own);
    vpa_pkg::in_req_t r;
    r.opcode = op;
    r.fit_policy = fit;
    r.request_size = sz;
    r.owner_id = own;
    return r;
  endfunction

  task automatic random_phase(int count, bit [7:0] owners);
    vpa_pkg::in_req_t r;
    int limit;
    for (int n = 0; n < count; n++) begin
      limit = (mem_size < 16) ? 16 : mem_size / 6;
      r = make_req($urandom_range(0, 99) < 55 ? vpa_pkg::OP_ALLOC : vpa_pkg::OP_FREE,
                   $urandom_range(0, 19) == 0 ? vpa_pkg::FIT_NONE :
                   2'($urandom_range(0, 2)),
                   16'($urandom_range(1, limit)), 8'($urandom_range(0, owners)));
      if ($urandom_range(0, 29) == 0) r.request_size = 16'($urandom);
      if ($urandom_range(0, 49) == 0) r.request_size = 0;
      if ($urandom_range(0, 19) == 0) r.owner_id = 8'($urandom);
      send_request(r);
    end
  endtask

  initial begin
    alloc_board = new();
    alloc_board.mismatches = 0;
    cycle_count = 0;
    burst_left = 0;
    rst_n = 0;
    start = 0;
    in_req = '0;
    cfg_we = 0;
    cfg_total_size = 16'd1024;
    mem_size = vpa_pkg::TOTAL_SIZE_RESET;
    alloc_board.clear_table(vpa_pkg::TOTAL_SIZE_RESET);
    repeat (8) @(negedge clk);
    rst_n <= 1;
    repeat (40) @(negedge clk);

    send_request(make_req(vpa_pkg::OP_ALLOC, vpa_pkg::FIT_FIRST, 16'd100, 8'd1));
    send_request(make_req(vpa_pkg::OP_ALLOC, vpa_pkg::FIT_BEST, 16'd50, 8'd2));
    send_request(make_req(vpa_pkg::OP_ALLOC, vpa_pkg::FIT_WORST, 16'd200, 8'd255));
    send_request(make_req(vpa_pkg::OP_ALLOC, vpa_pkg::FIT_NONE, 16'd10, 8'd3));
    send_request(make_req(vpa_pkg::OP_ALLOC, vpa_pkg::FIT_FIRST, 16'd0, 8'd3));
    send_request(make_req(vpa_pkg::OP_ALLOC, vpa_pkg::FIT_FIRST, 16'hFFFF, 8'd3));
    send_request(make_req(vpa_pkg::OP_FREE, vpa_pkg::FIT_FIRST, 16'd0, 8'd2));
    send_request(make_req(vpa_pkg::OP_ALLOC, vpa_pkg::FIT_BEST, 16'd30, 8'd0));
    send_request(make_req(vpa_pkg::OP_FREE, vpa_pkg::FIT_NONE, 16'hFFFF, 8'd0));
    send_request(make_req(vpa_pkg::OP_FREE, vpa_pkg::FIT_FIRST, 16'd0, 8'd0));
    send_request(make_req(vpa_pkg::OP_FREE, vpa_pkg::FIT_FIRST, 16'd0, 8'd77));
    send_request(make_req(vpa_pkg::OP_FREE, vpa_pkg::FIT_FIRST, 16'd0, 8'd255));
    send_request(make_req(vpa_pkg::OP_ALLOC, vpa_pkg::FIT_FIRST, 16'd674, 8'd4));
    send_request(make_req(vpa_pkg::OP_FREE, vpa_pkg::FIT_FIRST, 16'd0, 8'd4));
    send_request(make_req(vpa_pkg::OP_FREE, vpa_pkg::FIT_FIRST, 16'd0, 8'd1));

    write_size(16'd0);
    send_request(make_req(vpa_pkg::OP_ALLOC, vpa_pkg::FIT_FIRST, 16'd1, 8'd1));
    send_request(make_req(vpa_pkg::OP_FREE, vpa_pkg::FIT_FIRST, 16'd0, 8'd1));
    write_size(16'd40);
    for (int i = 0; i < 40; i++)
      send_request(make_req(vpa_pkg::OP_ALLOC, vpa_pkg::FIT_FIRST, 16'd1, 8'(i + 1)));
    random_phase(150, 8'd45);

    write_size(16'hFFFF);
    random_phase(500, 8'd20);
    write_size(16'd1);
    random_phase(60, 8'd3);
    write_size(16'd300);
    random_phase(600, 8'd12);
    wait_drained();
    write_size(16'($urandom_range(50, 5000)));
    random_phase(600, 8'd30);

    wait_drained();
    if (alloc_board.mismatches == 0 && alloc_board.pending_rsp.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

`default_nettype wire
